// File: src/bpa_pkg.sv
package bpa_pkg;

    // geometry of the managed frame space
    localparam int PAGE_COUNT = 4096;
    localparam int TOP_ORDER  = 10;
    localparam int NUM_ORD    = TOP_ORDER + 1;
    localparam int FRAME_W    = 12;
    localparam int LINK_W     = 13;
    localparam int PAGES_W    = 13;
    localparam int ORD_W      = 4;
    localparam int CNT_W      = 11;

    // list link that points nowhere
    localparam logic [LINK_W-1:0] LINK_NULL = 13'h1FFF;

    // page state codes, orders 0..TOP_ORDER mark a free block head
    localparam logic [ORD_W-1:0] ST_BODY  = 4'hD;
    localparam logic [ORD_W-1:0] ST_ALLOC = 4'hE;
    localparam logic [ORD_W-1:0] ST_RSVD  = 4'hF;

    // request opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    // response status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_NOMEM   = 2'd2;
    localparam logic [1:0] STAT_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [FRAME_W-1:0] frame;
        logic [PAGES_W-1:0] page_count;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] result_frame;
    } rsp_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_FINISH,
        DP_EMIT,
        DP_ADD_CLAMP,
        DP_ADD_SETUP,
        DP_ADD_STEP,
        DP_PUSH_A,
        DP_PUSH_B,
        DP_BODY,
        DP_ALLOC_INIT,
        DP_ALLOC_TAKE,
        DP_POP_LINK,
        DP_POP_CLR,
        DP_SPLIT,
        DP_MARK_INIT,
        DP_MARK,
        DP_FREE_RD,
        DP_FREE_INIT,
        DP_BUD_RD,
        DP_UL_HEAD,
        DP_UL_PRD,
        DP_UL_PNX,
        DP_UL_NX,
        DP_UL_PV,
        DP_FREE_PUSH
    } dp_op_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ADD_SETUP,
        S_PUSH_A,
        S_PUSH_B,
        S_BODY,
        S_ALLOC_SRCH,
        S_POP_LINK,
        S_POP_CLR,
        S_SPLIT,
        S_MARK,
        S_FREE_CHK,
        S_MERGE,
        S_BUDDY,
        S_PNEXT,
        S_UL_NX,
        S_UL_PV,
        S_FIN
    } ctl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] fin_status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op_code;
        logic       pages_zero;
        logic       frame_zero;
        logic       alloc_bad;
        logic       found;
        logic       st_alloc;
        logic       free_ok;
        logic       k_top;
        logic       bud_match;
        logic       p_null;
        logic       head_is_b;
        logic       pnext_is_b;
        logic       split_more;
        logic       cnt_zero;
        logic       clr_last;
        logic       out_free;
    } sts_t;

    // smallest order whose block holds the page count, capped at the top order
    function automatic logic [ORD_W-1:0] order_for(input logic [PAGES_W-1:0] pages);
        logic [ORD_W-1:0] k;
        k = ORD_W'(TOP_ORDER);
        for (int i = TOP_ORDER - 1; i >= 0; i--)
        begin
            if ((PAGES_W'(1) << i) >= pages)
                k = ORD_W'(i);
        end
        return k;
    endfunction

    // largest aligned block order that fits in the remaining range
    function automatic logic [ORD_W-1:0] add_order(input logic [PAGES_W-1:0] frame,
                                                   input logic [PAGES_W-1:0] pages);
        logic [ORD_W-1:0] k;
        k = '0;
        for (int i = 1; i <= TOP_ORDER; i++)
        begin
            if (((PAGES_W'(1) << i) <= pages) &&
                ((frame & ((PAGES_W'(1) << i) - PAGES_W'(1))) == '0))
                k = ORD_W'(i);
        end
        return k;
    endfunction

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < LINK_W'(PAGE_COUNT);
    endfunction

endpackage

// File: src/bpa_ctrl.sv
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (sts.clr_last)
                    state_next = S_IDLE;
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
                unique case (sts.op_code)
                    OP_ADD:
                        state_next = sts.pages_zero ? S_FIN : S_ADD_SETUP;
                    OP_ALLOC:
                        state_next = sts.alloc_bad ? S_FIN : S_ALLOC_SRCH;
                    OP_FREE:
                        state_next = (sts.frame_zero || sts.pages_zero) ? S_FIN : S_FREE_CHK;
                    default:
                        state_next = S_FIN;
                endcase
            S_ADD_SETUP:
                state_next = sts.pages_zero ? S_FIN : S_PUSH_A;
            S_PUSH_A:
                state_next = S_PUSH_B;
            S_PUSH_B:
                state_next = S_BODY;
            S_BODY:
                if (sts.cnt_zero)
                begin
                    priority case (sts.op_code)
                        OP_ADD:   state_next = S_ADD_SETUP;
                        OP_ALLOC: state_next = S_SPLIT;
                        default:  state_next = S_FIN;
                    endcase
                end
            S_ALLOC_SRCH:
                state_next = sts.found ? S_POP_LINK : S_FIN;
            S_POP_LINK:
                state_next = S_POP_CLR;
            S_POP_CLR:
                state_next = S_SPLIT;
            S_SPLIT:
                state_next = sts.split_more ? S_PUSH_A : S_MARK;
            S_MARK:
                if (sts.cnt_zero)
                    state_next = S_FIN;
            S_FREE_CHK:
                state_next = (sts.st_alloc && sts.free_ok) ? S_MERGE : S_FIN;
            S_MERGE:
                state_next = sts.k_top ? S_PUSH_A : S_BUDDY;
            S_BUDDY:
                priority if (!sts.bud_match)
                    state_next = S_PUSH_A;
                else if (sts.p_null)
                    state_next = sts.head_is_b ? S_UL_NX : S_PUSH_A;
                else
                    state_next = S_PNEXT;
            S_PNEXT:
                state_next = sts.pnext_is_b ? S_UL_NX : S_PUSH_A;
            S_UL_NX:
                state_next = S_UL_PV;
            S_UL_PV:
                state_next = S_MERGE;
            S_FIN:
                if (sts.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_CLEAR;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd.op         = DP_NOP;
        cmd.fin_status = STAT_OK;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
                cmd.op = DP_CLEAR;
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = DP_LOAD;
            end
            S_DECODE:
                unique case (sts.op_code)
                    OP_ADD:
                        cmd.op = sts.pages_zero ? DP_FINISH : DP_ADD_CLAMP;
                    OP_ALLOC:
                    begin
                        cmd.op         = sts.alloc_bad ? DP_FINISH : DP_ALLOC_INIT;
                        cmd.fin_status = STAT_INVALID;
                    end
                    OP_FREE:
                    begin
                        cmd.op = (sts.frame_zero || sts.pages_zero) ? DP_FINISH : DP_FREE_RD;
                        cmd.fin_status = STAT_IGNORED;
                    end
                    default:
                    begin
                        cmd.op         = DP_FINISH;
                        cmd.fin_status = STAT_INVALID;
                    end
                endcase
            S_ADD_SETUP:
                cmd.op = sts.pages_zero ? DP_FINISH : DP_ADD_SETUP;
            S_PUSH_A:
                cmd.op = DP_PUSH_A;
            S_PUSH_B:
                cmd.op = DP_PUSH_B;
            S_BODY:
                if (!sts.cnt_zero)
                    cmd.op = DP_BODY;
                else if (sts.op_code == OP_ADD)
                    cmd.op = DP_ADD_STEP;
                else if (sts.op_code == OP_FREE)
                    cmd.op = DP_FINISH;
            S_ALLOC_SRCH:
            begin
                cmd.op         = sts.found ? DP_ALLOC_TAKE : DP_FINISH;
                cmd.fin_status = STAT_NOMEM;
            end
            S_POP_LINK:
                cmd.op = DP_POP_LINK;
            S_POP_CLR:
                cmd.op = DP_POP_CLR;
            S_SPLIT:
                cmd.op = sts.split_more ? DP_SPLIT : DP_MARK_INIT;
            S_MARK:
                cmd.op = sts.cnt_zero ? DP_FINISH : DP_MARK;
            S_FREE_CHK:
            begin
                cmd.op = (sts.st_alloc && sts.free_ok) ? DP_FREE_INIT : DP_FINISH;
                cmd.fin_status = STAT_IGNORED;
            end
            S_MERGE:
                cmd.op = sts.k_top ? DP_FREE_PUSH : DP_BUD_RD;
            S_BUDDY:
                priority if (!sts.bud_match)
                    cmd.op = DP_FREE_PUSH;
                else if (sts.p_null)
                    cmd.op = sts.head_is_b ? DP_UL_HEAD : DP_FREE_PUSH;
                else
                    cmd.op = DP_UL_PRD;
            S_PNEXT:
                cmd.op = sts.pnext_is_b ? DP_UL_PNX : DP_FREE_PUSH;
            S_UL_NX:
                cmd.op = DP_UL_NX;
            S_UL_PV:
                cmd.op = DP_UL_PV;
            S_FIN:
                if (sts.out_free)
                    cmd.op = DP_EMIT;
            default:
                cmd.op = DP_NOP;
        endcase
    end

endmodule

// File: src/bpa_dp.sv
module bpa_dp
    import bpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output sts_t sts,
    input  req_t in_req,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_rsp
);

    // per-frame stores
    logic [ORD_W-1:0]  st_mem [PAGE_COUNT];
    logic [LINK_W-1:0] nx_mem [PAGE_COUNT];
    logic [LINK_W-1:0] pv_mem [PAGE_COUNT];

    logic [LINK_W-1:0] head_reg [NUM_ORD];

    logic [FRAME_W-1:0] clr_reg;
    logic               out_valid_reg;
    rsp_t               out_rsp_reg;

    logic [1:0]         op_reg;
    logic [PAGES_W-1:0] frame_reg;
    logic [PAGES_W-1:0] pages_reg;
    logic [ORD_W-1:0]   k_reg;
    logic [ORD_W-1:0]   want_reg;
    logic [ORD_W-1:0]   pk_reg;
    logic [FRAME_W-1:0] blk_reg;
    logic [FRAME_W-1:0] base_reg;
    logic [FRAME_W-1:0] cur_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LINK_W-1:0]  p_reg;
    logic [LINK_W-1:0]  n_reg;
    logic [FRAME_W-1:0] b_reg;
    logic [1:0]         fin_status_reg;

    logic [ORD_W-1:0]  st_rd;
    logic [LINK_W-1:0] nx_rd;
    logic [LINK_W-1:0] pv_rd;

    logic               st_we, nx_we, pv_we;
    logic [FRAME_W-1:0] st_wa, nx_wa, pv_wa;
    logic [ORD_W-1:0]   st_wd;
    logic [LINK_W-1:0]  nx_wd, pv_wd;
    logic [FRAME_W-1:0] st_ra, nx_ra, pv_ra;

    logic               found;
    logic [ORD_W-1:0]   found_k;
    logic [ORD_W-1:0]   free_k;
    logic [PAGES_W-1:0] free_sz;
    logic [PAGES_W-1:0] pk_sz;
    logic [ORD_W-1:0]   add_k;
    logic [FRAME_W-1:0] buddy;
    logic [LINK_W-1:0]  head_pk;
    logic               free_ok;
    logic               out_free;

    // lowest non-empty list at or above the wanted order
    always_comb
    begin
        found   = 1'b0;
        found_k = '0;
        for (int i = 0; i < NUM_ORD; i++)
        begin
            if (!found && (ORD_W'(i) >= want_reg) && link_ok(head_reg[i]))
            begin
                found   = 1'b1;
                found_k = ORD_W'(i);
            end
        end
    end

    // block geometry
    assign free_k  = order_for(pages_reg);
    assign free_sz = PAGES_W'(1) << free_k;
    assign pk_sz   = PAGES_W'(1) << pk_reg;
    assign add_k   = add_order(frame_reg, pages_reg);
    assign buddy   = frame_reg[FRAME_W-1:0] ^ (FRAME_W'(1) << k_reg);
    assign head_pk = head_reg[pk_reg];
    assign free_ok = ((frame_reg & (free_sz - PAGES_W'(1))) == '0) &&
                     ((14'(frame_reg) + 14'(free_sz)) <= 14'(PAGE_COUNT));
    assign out_free = !out_valid_reg || out_ready;

    // status to the controller
    always_comb
    begin
        sts.op_code    = op_reg;
        sts.pages_zero = (pages_reg == '0);
        sts.frame_zero = (frame_reg == '0);
        sts.alloc_bad  = (pages_reg == '0) || (pages_reg > (PAGES_W'(1) << TOP_ORDER));
        sts.found      = found;
        sts.st_alloc   = (st_rd == ST_ALLOC);
        sts.free_ok    = free_ok;
        sts.k_top      = (k_reg == ORD_W'(TOP_ORDER));
        sts.bud_match  = (st_rd == k_reg);
        sts.p_null     = !link_ok(pv_rd);
        sts.head_is_b  = (head_reg[k_reg] == {1'b0, b_reg});
        sts.pnext_is_b = (nx_rd == {1'b0, b_reg});
        sts.split_more = (k_reg > want_reg);
        sts.cnt_zero   = (cnt_reg == '0);
        sts.clr_last   = (clr_reg == '1);
        sts.out_free   = out_free;
    end

    // memory port muxing
    always_comb
    begin
        st_we = 1'b0;  st_wa = clr_reg;  st_wd = ST_RSVD;
        nx_we = 1'b0;  nx_wa = clr_reg;  nx_wd = LINK_NULL;
        pv_we = 1'b0;  pv_wa = clr_reg;  pv_wd = LINK_NULL;
        st_ra = buddy;
        nx_ra = buddy;
        pv_ra = buddy;
        unique case (cmd.op)
            DP_CLEAR:
            begin
                st_we = 1'b1;
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            DP_PUSH_A:
            begin
                st_we = 1'b1;  st_wa = blk_reg;  st_wd = pk_reg;
                nx_we = 1'b1;  nx_wa = blk_reg;  nx_wd = head_pk;
                pv_we = link_ok(head_pk);
                pv_wa = head_pk[FRAME_W-1:0];
                pv_wd = {1'b0, blk_reg};
            end
            DP_PUSH_B:
            begin
                pv_we = 1'b1;  pv_wa = blk_reg;
            end
            DP_BODY:
            begin
                st_we = 1'b1;  st_wa = cur_reg;  st_wd = ST_BODY;
            end
            DP_MARK:
            begin
                st_we = 1'b1;  st_wa = cur_reg;  st_wd = ST_ALLOC;
            end
            DP_ALLOC_TAKE:
                nx_ra = head_reg[found_k][FRAME_W-1:0];
            DP_POP_LINK:
            begin
                nx_we = 1'b1;  nx_wa = base_reg;
                pv_we = link_ok(nx_rd);
                pv_wa = nx_rd[FRAME_W-1:0];
            end
            DP_POP_CLR:
            begin
                pv_we = 1'b1;  pv_wa = base_reg;
            end
            DP_FREE_RD:
                st_ra = frame_reg[FRAME_W-1:0];
            DP_UL_PRD:
                nx_ra = pv_rd[FRAME_W-1:0];
            DP_UL_PNX:
            begin
                nx_we = 1'b1;  nx_wa = p_reg[FRAME_W-1:0];  nx_wd = n_reg;
            end
            DP_UL_NX:
            begin
                nx_we = 1'b1;  nx_wa = b_reg;
                pv_we = link_ok(n_reg);
                pv_wa = n_reg[FRAME_W-1:0];
                pv_wd = p_reg;
            end
            DP_UL_PV:
            begin
                pv_we = 1'b1;  pv_wa = b_reg;
            end
            default:
            begin
            end
        endcase
    end

    // stores, registered read data
    always_ff @(posedge clk)
    begin
        if (st_we)
            st_mem[st_wa] <= st_wd;
        st_rd <= st_mem[st_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
            nx_mem[nx_wa] <= nx_wd;
        nx_rd <= nx_mem[nx_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
            pv_mem[pv_wa] <= pv_wd;
        pv_rd <= pv_mem[pv_ra];
    end

    // control registers: clear sweep, list heads, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ORD; i++)
                head_reg[i] <= LINK_NULL;
        end
        else
        begin
            if (cmd.op == DP_CLEAR)
                clr_reg <= clr_reg + FRAME_W'(1);
            if (cmd.op == DP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (cmd.op)
                DP_PUSH_A:  head_reg[pk_reg] <= {1'b0, blk_reg};
                DP_POP_LINK: head_reg[k_reg] <= nx_rd;
                DP_UL_HEAD: head_reg[k_reg] <= nx_rd;
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:
            begin
                op_reg    <= in_req.op;
                frame_reg <= PAGES_W'(in_req.frame);
                pages_reg <= in_req.page_count;
            end
            DP_FINISH:
                fin_status_reg <= cmd.fin_status;
            DP_EMIT:
            begin
                out_rsp_reg.status <= fin_status_reg;
                out_rsp_reg.result_frame <=
                    (op_reg == OP_ALLOC && fin_status_reg == STAT_OK) ? base_reg : '0;
            end
            DP_ADD_CLAMP:
                if (pages_reg > (PAGES_W'(PAGE_COUNT) - frame_reg))
                    pages_reg <= PAGES_W'(PAGE_COUNT) - frame_reg;
            DP_ADD_SETUP:
            begin
                blk_reg <= frame_reg[FRAME_W-1:0];
                pk_reg  <= add_k;
            end
            DP_ADD_STEP:
            begin
                frame_reg <= frame_reg + pk_sz;
                pages_reg <= pages_reg - pk_sz;
            end
            DP_PUSH_B:
            begin
                cur_reg <= blk_reg + FRAME_W'(1);
                cnt_reg <= (CNT_W'(1) << pk_reg) - CNT_W'(1);
            end
            DP_BODY, DP_MARK:
            begin
                cur_reg <= cur_reg + FRAME_W'(1);
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            DP_ALLOC_INIT:
                want_reg <= free_k;
            DP_ALLOC_TAKE:
            begin
                k_reg    <= found_k;
                base_reg <= head_reg[found_k][FRAME_W-1:0];
            end
            DP_SPLIT:
            begin
                k_reg   <= k_reg - ORD_W'(1);
                pk_reg  <= k_reg - ORD_W'(1);
                blk_reg <= base_reg + (FRAME_W'(1) << (k_reg - ORD_W'(1)));
            end
            DP_MARK_INIT:
            begin
                cur_reg <= base_reg;
                cnt_reg <= CNT_W'(1) << want_reg;
            end
            DP_FREE_INIT:
                k_reg <= free_k;
            DP_BUD_RD:
                b_reg <= buddy;
            DP_UL_HEAD, DP_UL_PRD:
            begin
                p_reg <= pv_rd;
                n_reg <= nx_rd;
            end
            DP_UL_PV:
            begin
                if ({1'b0, b_reg} < frame_reg)
                    frame_reg <= {1'b0, b_reg};
                k_reg <= k_reg + ORD_W'(1);
            end
            DP_FREE_PUSH:
            begin
                blk_reg <= frame_reg[FRAME_W-1:0];
                pk_reg  <= k_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    // a response is only loaded into a free output slot
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_EMIT) |-> out_free)
        else $error("response loaded over a pending response");

    // page sweeps never run past their count
    a_sweep_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_BODY || cmd.op == DP_MARK) |-> (cnt_reg != '0))
        else $error("page sweep with zero count");

    // splitting only happens above the wanted order
    a_split_ord: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_SPLIT) |-> (k_reg > want_reg))
        else $error("split below wanted order");

    // merging climbs one order per buddy
    a_merge_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_UL_PV) |=> (k_reg == $past(k_reg) + ORD_W'(1)))
        else $error("merge order did not advance");

endmodule

// File: src/buddy_page_allocator_unit.sv
// channel   signals                       payload
// in        in_valid / in_ready           in_req  : op, frame, page_count
// out       out_valid / out_ready         out_rsp : status, result_frame
//
// after reset the page state and link stores are swept, one frame a cycle,
// over all 4096 frames; no request is taken until the sweep ends
// one request is worked at a time; besides list work, it rewrites the state of
// each page it covers in turn (block bodies and allocated pages)
// free also walks the buddy read, unlink and climb states for each buddy merged
// a finished response waits in the output register; a new request is taken
// while it waits, and only the next response stalls behind it
module buddy_page_allocator_unit
    import bpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_req,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_rsp
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stores, lists and working registers
    bpa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp)
    );

endmodule

// File: verif/buddy_page_allocator_unit_test.sv
module buddy_page_allocator_unit_test
    import bpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BODY_PAGE   = 253;
    localparam int ALLOCATED   = 254;
    localparam int RESERVED    = 255;
    localparam int NO_LINK     = -1;
    localparam int CYCLE_LIMIT = 6000000;

    // opcode outside the defined set
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_req;
    logic out_valid;
    logic out_ready;
    rsp_t out_rsp;

    buddy_page_allocator_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_rsp  (out_rsp)
    );

    // predicted allocator state
    int pg_state [PAGE_COUNT];
    int fwd_link [PAGE_COUNT];
    int back_link[PAGE_COUNT];
    int order_head[NUM_ORD];

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    // live allocations, frame and page count, used to build sensible frees
    int live_frames[$];
    int live_pages[$];

    int  errors;
    int  cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  hold_cycles;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int order_of(int pages);
        int k;
        k = 0;
        while ((1 << k) < pages && k < TOP_ORDER)
            k++;
        return k;
    endfunction

    function automatic void set_state(int f, int v);
        if (f < PAGE_COUNT)
            pg_state[f] = v;
    endfunction

    function automatic void list_push(int f, int k);
        int h;
        if (f >= PAGE_COUNT || k > TOP_ORDER)
            return;
        set_state(f, k);
        for (int i = 1; i < (1 << k); i++)
            set_state(f + i, BODY_PAGE);
        h = order_head[k];
        if (h >= 0 && h < PAGE_COUNT)
            back_link[h] = f;
        back_link[f] = NO_LINK;
        fwd_link[f] = h;
        order_head[k] = f;
    endfunction

    function automatic bit list_unlink(int f, int k);
        int p;
        int n;
        p = back_link[f];
        n = fwd_link[f];
        if (p < 0)
        begin
            if (order_head[k] != f)
                return 1'b0;
            order_head[k] = n;
        end
        else if (fwd_link[p] != f)
        begin
            return 1'b0;
        end
        else
        begin
            fwd_link[p] = n;
        end
        if (n >= 0)
            back_link[n] = p;
        fwd_link[f] = NO_LINK;
        back_link[f] = NO_LINK;
        return 1'b1;
    endfunction

    function automatic int list_pop(int k);
        int f;
        int n;
        f = order_head[k];
        if (f < 0)
            return NO_LINK;
        n = fwd_link[f];
        order_head[k] = n;
        if (n >= 0)
            back_link[n] = NO_LINK;
        fwd_link[f] = NO_LINK;
        back_link[f] = NO_LINK;
        return f;
    endfunction

    // work out the response of one request and update the predicted state
    function automatic rsp_t allocator_predict(req_t r);
        rsp_t rsp;
        int   frame;
        int   pages;
        int   k;
        int   want;
        int   f;
        int   b;
        frame = int'(r.frame);
        pages = int'(r.page_count);
        rsp.status = STAT_INVALID;
        rsp.result_frame = '0;
        if (r.op == OP_ADD)
        begin
            rsp.status = STAT_OK;
            if (pages > PAGE_COUNT - frame)
                pages = PAGE_COUNT - frame;
            while (pages > 0)
            begin
                k = TOP_ORDER;
                while (k > 0 && ((1 << k) > pages || (frame & ((1 << k) - 1)) != 0))
                    k--;
                list_push(frame, k);
                frame += 1 << k;
                pages -= 1 << k;
            end
        end
        else if (r.op == OP_ALLOC)
        begin
            if (pages != 0 && pages <= (1 << TOP_ORDER))
            begin
                want = order_of(pages);
                rsp.status = STAT_NOMEM;
                for (k = want; k <= TOP_ORDER; k++)
                begin
                    if (order_head[k] < 0)
                        continue;
                    f = list_pop(k);
                    while (k > want)
                    begin
                        k--;
                        list_push(f + (1 << k), k);
                    end
                    for (int i = 0; i < (1 << want); i++)
                        set_state(f + i, ALLOCATED);
                    rsp.status = STAT_OK;
                    rsp.result_frame = f[FRAME_W-1:0];
                    break;
                end
            end
        end
        else if (r.op == OP_FREE)
        begin
            rsp.status = STAT_IGNORED;
            if (frame != 0 && pages != 0 && pg_state[frame] == ALLOCATED)
            begin
                k = order_of(pages);
                if ((frame & ((1 << k) - 1)) == 0 && (1 << k) <= PAGE_COUNT - frame)
                begin
                    rsp.status = STAT_OK;
                    while (k < TOP_ORDER)
                    begin
                        b = frame ^ (1 << k);
                        if (b >= PAGE_COUNT)
                            break;
                        if (pg_state[b] != k)
                            break;
                        if (!list_unlink(b, k))
                            break;
                        if (b < frame)
                            frame = b;
                        k++;
                    end
                    list_push(frame, k);
                end
            end
        end
        return rsp;
    endfunction

    function automatic req_t make_req(logic [1:0] op, int frame, int pages);
        req_t r;
        r.op = op;
        r.frame = frame[FRAME_W-1:0];
        r.page_count = pages[PAGES_W-1:0];
        return r;
    endfunction

    function automatic int rand_pages();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return $urandom_range(1, 8);
        else if (sel < 85)
            return $urandom_range(1, 64);
        else if (sel < 97)
            return $urandom_range(1, 1024);
        else
            return $urandom_range(0, 8191);
    endfunction

    // one random request, mostly allocs and frees of live blocks
    function automatic req_t rand_req();
        int sel;
        int idx;
        req_t r;
        sel = $urandom_range(0, 99);
        if (sel < 5)
        begin
            r = make_req(OP_ADD, $urandom_range(0, PAGE_COUNT - 1), rand_pages());
        end
        else if (sel < 50)
        begin
            r = make_req(OP_ALLOC, 0, rand_pages());
            r.frame = FRAME_W'($urandom);
        end
        else if (sel < 88 && live_frames.size() > 0)
        begin
            idx = $urandom_range(0, live_frames.size() - 1);
            r = make_req(OP_FREE, live_frames[idx], live_pages[idx]);
            live_frames.delete(idx);
            live_pages.delete(idx);
        end
        else if (sel < 97)
        begin
            r = make_req(OP_FREE, $urandom_range(0, PAGE_COUNT - 1), rand_pages());
        end
        else
        begin
            r = make_req(OP_UNUSED, $urandom, $urandom);
        end
        return r;
    endfunction

    // predict on generation, in request order; remember successful allocations
    task automatic queue_req(req_t r);
        rsp_t e;
        e = allocator_predict(r);
        if (r.op == OP_ALLOC && e.status == STAT_OK)
        begin
            live_frames.push_back(int'(e.result_frame));
            live_pages.push_back(int'(r.page_count));
        end
        pending_reqs.push_back(r);
        expected_rsps.push_back(e);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_req   <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_req   <= pending_reqs.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cycles <= 0;
        end
        else if (recv_hold && hold_cycles < 3000)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response status=%0d frame=%0d",
                       out_rsp.status, out_rsp.result_frame);
                errors++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (out_rsp.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, out_rsp.status);
                    errors++;
                end
                if (out_rsp.result_frame !== e.result_frame)
                begin
                    $error("result_frame expected %0d actual %0d",
                           e.result_frame, out_rsp.result_frame);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("buddy_page_allocator_unit_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 22;
        recv_idle_pct = 88;
        recv_hold = 1'b0;
        for (int i = 0; i < PAGE_COUNT; i++)
        begin
            pg_state[i] = RESERVED;
            fwd_link[i] = NO_LINK;
            back_link[i] = NO_LINK;
        end
        for (int i = 0; i < NUM_ORD; i++)
            order_head[i] = NO_LINK;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty allocator, bad ops, edge ranges
        queue_req(make_req(OP_ALLOC, 0, 1));
        queue_req(make_req(OP_FREE, 5, 1));
        queue_req(make_req(OP_UNUSED, 12'hFFF, 13'h1FFF));
        queue_req(make_req(OP_ADD, 100, 0));
        queue_req(make_req(OP_ADD, 4095, 8191));
        queue_req(make_req(OP_ADD, 3, 1000));
        queue_req(make_req(OP_ADD, 0, 4096));
        queue_req(make_req(OP_ADD, 2048, 100));
        queue_req(make_req(OP_ALLOC, 0, 0));
        queue_req(make_req(OP_ALLOC, 0, 1025));
        queue_req(make_req(OP_ALLOC, 0, 8191));
        queue_req(make_req(OP_ALLOC, 0, 1024));
        queue_req(make_req(OP_ALLOC, 0, 1));
        queue_req(make_req(OP_ALLOC, 0, 3));
        queue_req(make_req(OP_FREE, 0, 1));
        queue_req(make_req(OP_FREE, 4095, 1));
        queue_req(make_req(OP_FREE, 1024, 0));
        queue_req(make_req(OP_FREE, 1, 4));
        queue_req(make_req(OP_FREE, 1024, 8191));
        for (int i = 0; i < 6; i++)
            queue_req(make_req(OP_ALLOC, 0, 1024));
        live_frames.delete();
        live_pages.delete();

        for (int n = 0; n < 1950; n++)
        begin
            if (n == 650)
            begin
                wait_drained();
                send_idle_pct = 88;
                recv_idle_pct = 22;
            end
            if (n == 1000)
            begin
                // long receiver hold while requests keep coming
                wait_drained();
                send_idle_pct = 0;
                recv_hold = 1'b1;
            end
            if (n == 1300)
            begin
                wait_drained();
                recv_hold = 1'b0;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // occasionally re-add all memory so allocations keep succeeding
            if (n % 300 == 299)
                queue_req(make_req(OP_ADD, 0, 4096));
            else
                queue_req(rand_req());
            if (live_frames.size() > 400)
            begin
                live_frames.delete();
                live_pages.delete();
            end
        end
        wait_drained();
        repeat (3000) @(posedge clk);
        if (errors == 0)
            $display("buddy_page_allocator_unit_test: PASS");
        else
            $display("buddy_page_allocator_unit_test: FAIL");
        $finish;
    end

endmodule
